[hdl/keycode_alarm_controller_macros.svh]
// Assertion macros used by the alarm panel top level.
`ifndef KEYCODE_ALARM_CONTROLLER_MACROS_SVH
`define KEYCODE_ALARM_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alarm panel check failed");

// Next-cycle implication, checked outside reset
`define KAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alarm panel check failed");

`endif

[hdl/kac_pkg.sv]
// Shared types, key codes and message codes of the alarm panel.
`default_nettype none
package kac_pkg;

  localparam int CODE_LENGTH_DEF = 4;
  localparam int NUM_CODE_DIGITS = 4;
  localparam int NUM_DIGIT_KEYS  = 10;

  // Remote key codes
  localparam logic [31:0] KEY_ARM    = 32'h00FF_906F;
  localparam logic [31:0] KEY_DISARM = 32'h00FF_E01F;
  localparam logic [31:0] DIGIT_KEYS [NUM_DIGIT_KEYS] = '{
    32'h00FF_6897, 32'h00FF_30CF, 32'h00FF_18E7, 32'h00FF_7A85, 32'h00FF_10EF,
    32'h00FF_38C7, 32'h00FF_5AA5, 32'h00FF_42BD, 32'h00FF_4AB5, 32'h00FF_52AD
  };

  // Configuration register indexes
  localparam logic [1:0] REG_CODE_DIGIT0 = 2'd0;
  localparam logic [1:0] REG_CODE_DIGIT3 = 2'd3;

  typedef enum logic [2:0] {
    MSG_NONE       = 3'd0,
    MSG_ASK_ARM    = 3'd1,
    MSG_ASK_DISARM = 3'd2,
    MSG_DIGIT      = 3'd3,
    MSG_RETRY      = 3'd4,
    MSG_ARMED      = 3'd5,
    MSG_DISARMED   = 3'd6,
    MSG_DETECTED   = 3'd7
  } msg_t;

  // Decoded remote key
  typedef struct packed {
    logic       is_arm;
    logic       is_disarm;
    logic       is_digit;
    logic [3:0] digit;
  } key_t;

  // One result transaction
  typedef struct packed {
    logic       armed;
    logic       alert;
    logic       buzzer;
    msg_t       message;
    logic [3:0] shown_digit;
  } result_t;

endpackage
`default_nettype wire

[hdl/kac_key_decode.sv]
// Decoder from a 32-bit remote code to arm, disarm and digit keys.
`default_nettype none
module kac_key_decode (
  input  wire logic [31:0] ir_code,
  output kac_pkg::key_t    key
);
  import kac_pkg::*;

  // Parallel match against every known key
  always_comb begin
    key.is_arm    = (ir_code == KEY_ARM);
    key.is_disarm = (ir_code == KEY_DISARM);
    key.is_digit  = 1'b0;
    key.digit     = '0;
    for (int d = 0; d < NUM_DIGIT_KEYS; d++) begin
      if (ir_code == DIGIT_KEYS[d]) begin
        key.is_digit = 1'b1;
        key.digit    = 4'(d);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/kac_core.sv]
// Panel state, stored passcode and the single-pass update of one event.
`default_nettype none
module kac_core #(
  parameter int CODE_LENGTH = kac_pkg::CODE_LENGTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [3:0]      cfg_wdata,
  input  wire logic            upd_en,
  input  wire logic            kind,
  input  wire kac_pkg::key_t   key,
  input  wire logic            motion_level,
  input  wire logic            button_level,
  output kac_pkg::result_t     res_nxt
);
  import kac_pkg::*;

  localparam logic [2:0] LEN = 3'(CODE_LENGTH);

  logic [3:0] code_r    [NUM_CODE_DIGITS];
  logic [3:0] entered_r [NUM_CODE_DIGITS];
  logic [3:0] entered_nxt [NUM_CODE_DIGITS];
  logic       armed_r, armed_nxt;
  logic       arm_req_r, arm_req_nxt;
  logic       disarm_req_r, disarm_req_nxt;
  logic [2:0] count_r, count_nxt;
  logic       motion_seen_r, motion_seen_nxt;
  logic       last_button_r, last_button_nxt;
  logic       alert_r, alert_nxt;
  logic       buzzer_r, buzzer_nxt;
  msg_t       msg_r, msg_nxt;
  logic [3:0] digit_r, digit_nxt;
  logic       same;

  // Entry matches the stored code over the active length
  always_comb begin
    same = 1'b1;
    for (int k = 0; k < NUM_CODE_DIGITS; k++) begin
      if (k < CODE_LENGTH && code_r[k] != entered_r[k]) begin
        same = 1'b0;
      end
    end
  end

  // Next state for one event
  always_comb begin
    armed_nxt       = armed_r;
    arm_req_nxt     = arm_req_r;
    disarm_req_nxt  = disarm_req_r;
    count_nxt       = count_r;
    motion_seen_nxt = motion_seen_r;
    last_button_nxt = last_button_r;
    alert_nxt       = alert_r;
    buzzer_nxt      = buzzer_r;
    msg_nxt         = msg_r;
    digit_nxt       = digit_r;
    entered_nxt     = entered_r;
    if (!kind) begin
      // settle a pending entry
      if (count_r > LEN) begin
        msg_nxt   = MSG_RETRY;
        count_nxt = '0;
      end else if (count_r == LEN) begin
        if (same) begin
          if (arm_req_r) begin
            armed_nxt = 1'b1;
            msg_nxt   = MSG_ARMED;
            count_nxt = '0;
          end else if (disarm_req_r) begin
            armed_nxt  = 1'b0;
            msg_nxt    = MSG_DISARMED;
            buzzer_nxt = 1'b0;
            count_nxt  = '0;
          end
        end else begin
          msg_nxt   = MSG_RETRY;
          count_nxt = '0;
        end
        arm_req_nxt    = 1'b0;
        disarm_req_nxt = 1'b0;
      end
      // request keys
      if (key.is_arm) begin
        msg_nxt     = MSG_ASK_ARM;
        arm_req_nxt = 1'b1;
      end else if (key.is_disarm) begin
        msg_nxt        = MSG_ASK_DISARM;
        disarm_req_nxt = 1'b1;
      end
      // digit entry while a request is pending; an extra digit is only counted
      if ((arm_req_nxt || disarm_req_nxt) && key.is_digit) begin
        msg_nxt   = MSG_DIGIT;
        digit_nxt = key.digit;
        if (count_nxt < LEN) begin
          entered_nxt[count_nxt[1:0]] = key.digit;
        end
        if (count_nxt <= LEN) begin
          count_nxt = count_nxt + 3'd1;
        end
      end
    end else begin
      // motion rising edge while armed
      if (armed_r) begin
        if (motion_level) begin
          if (!motion_seen_r) begin
            alert_nxt       = 1'b1;
            msg_nxt         = MSG_DETECTED;
            buzzer_nxt      = 1'b1;
            motion_seen_nxt = 1'b1;
          end
        end else begin
          motion_seen_nxt = 1'b0;
        end
      end
      // button press toggles arming
      if (last_button_r && !button_level) begin
        if (!armed_r) begin
          armed_nxt = 1'b1;
          msg_nxt   = MSG_ARMED;
        end else begin
          armed_nxt       = 1'b0;
          msg_nxt         = MSG_DISARMED;
          motion_seen_nxt = 1'b0;
        end
      end
      last_button_nxt = button_level;
    end
  end

  // Result after this event
  always_comb begin
    res_nxt.armed       = armed_nxt;
    res_nxt.alert       = alert_nxt;
    res_nxt.buzzer      = buzzer_nxt;
    res_nxt.message     = msg_nxt;
    res_nxt.shown_digit = (msg_nxt == MSG_DIGIT) ? digit_nxt : 4'd0;
  end

  // State and passcode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      arm_req_r     <= 1'b0;
      disarm_req_r  <= 1'b0;
      count_r       <= '0;
      motion_seen_r <= 1'b0;
      last_button_r <= 1'b0;
      alert_r       <= 1'b0;
      buzzer_r      <= 1'b0;
      msg_r         <= MSG_NONE;
      digit_r       <= '0;
      for (int k = 0; k < NUM_CODE_DIGITS; k++) begin
        entered_r[k] <= '0;
        code_r[k]    <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        code_r[cfg_index] <= cfg_wdata;
      end
      if (upd_en) begin
        armed_r       <= armed_nxt;
        arm_req_r     <= arm_req_nxt;
        disarm_req_r  <= disarm_req_nxt;
        count_r       <= count_nxt;
        motion_seen_r <= motion_seen_nxt;
        last_button_r <= last_button_nxt;
        alert_r       <= alert_nxt;
        buzzer_r      <= buzzer_nxt;
        msg_r         <= msg_nxt;
        digit_r       <= digit_nxt;
        entered_r     <= entered_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/keycode_alarm_controller.sv]
// Top level of the keypad code lock alarm panel.
// Each input transaction (a remote key event or a motion/button sample) passes
// an input register, is applied to the panel state and leaves
// through a result register: one result transaction per input, and a new input
// is taken every cycle while the result side keeps up, so the sustained rate is
// one transaction per clock. The passcode must be written through the cfg_ port
// (index 0 to 3, first to fourth digit) while the panel is idle; the block itself
// does not enforce this, and no clearing pass follows reset.
`default_nettype none
`include "keycode_alarm_controller_macros.svh"
module keycode_alarm_controller #(
  parameter int CODE_LENGTH = kac_pkg::CODE_LENGTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [31:0] in_ir_code,
  input  wire logic        in_motion_level,
  input  wire logic        in_button_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_armed,
  output logic             out_alert,
  output logic             out_buzzer,
  output logic [2:0]       out_message,
  output logic [3:0]       out_shown_digit
);
  import kac_pkg::*;

  logic        in_valid_r;
  logic        kind_r;
  logic [31:0] ir_code_r;
  logic        motion_r;
  logic        button_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res_nxt;
  key_t        key;
  logic        out_free;
  logic        advance;
  logic        in_take;

  // Handshake: the input stage moves on when the result register is free
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r    <= in_kind;
      ir_code_r <= in_ir_code;
      motion_r  <= in_motion_level;
      button_r  <= in_button_level;
    end
  end

  kac_key_decode u_decode (
    .ir_code (ir_code_r),
    .key     (key)
  );

  kac_core #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .upd_en       (advance),
    .kind         (kind_r),
    .key          (key),
    .motion_level (motion_r),
    .button_level (button_r),
    .res_nxt      (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_armed       = res_r.armed;
  assign out_alert       = res_r.alert;
  assign out_buzzer      = res_r.buzzer;
  assign out_message     = res_r.message;
  assign out_shown_digit = res_r.shown_digit;

  // Checks
  `KAC_ASSERT_NOW(a_digit_only_with_msg, clk, rst_n, out_valid_r && res_r.shown_digit != 4'd0, res_r.message == MSG_DIGIT)
  `KAC_ASSERT_NOW(a_digit_range, clk, rst_n, out_valid_r, res_r.shown_digit <= 4'd9)
  `KAC_ASSERT_NEXT(a_held_item_kept, clk, rst_n, in_valid_r && !out_free, in_valid_r && out_valid_r)
  `KAC_ASSERT_NEXT(a_no_invented_result, clk, rst_n, !in_valid_r && out_free, !out_valid_r)

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the alarm panel: remote keys, sensor samples, passcode writes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kac_pkg::*;

  localparam int CODE_LEN    = CODE_LENGTH_DEF;
  localparam int ITEM_TARGET = 1300;
  localparam int PHASE_ITEMS = 220;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [31:0] in_ir_code;
  logic        in_motion_level;
  logic        in_button_level;
  logic        out_valid;
  logic        out_stall;
  logic        out_armed;
  logic        out_alert;
  logic        out_buzzer;
  logic [2:0]  out_message;
  logic [3:0]  out_shown_digit;

  bit      burst_mode;
  int      sent;
  int      passcodes_loaded;
  bit      motion_now;
  bit      button_now;
  result_t seen_result;

  // Tracks the panel state and holds the results still owed by the block
  class panel_predictor;
    bit [3:0] passcode [NUM_CODE_DIGITS];
    bit [3:0] entered [NUM_CODE_DIGITS];
    bit       armed, arm_req, disarm_req, motion_seen, last_button, alert, buzzer;
    bit [2:0] digit_count;
    msg_t     msg;
    bit [3:0] held_digit;
    result_t  expected_results [$];
    int       mismatches, checked, n_armed, n_detected, n_retry;

    function new();
      msg = MSG_NONE;
    endfunction

    function void set_passcode_digit(int idx, bit [3:0] value);
      passcode[idx] = value;
    endfunction

    // Apply one accepted input transaction and queue the result it causes
    function void note_event(bit kind, bit [31:0] code, bit motion, bit button);
      bit      same;
      int      k;
      result_t res;
      if (!kind) begin
        // a pending entry is settled before the key itself is looked at
        if (digit_count > CODE_LEN) begin
          msg = MSG_RETRY;
          digit_count = 0;
        end else if (digit_count == CODE_LEN) begin
          same = 1'b1;
          for (k = 0; k < CODE_LEN; k++)
            if (passcode[k] != entered[k]) same = 1'b0;
          if (!same) begin
            msg = MSG_RETRY;
            digit_count = 0;
          end else if (arm_req) begin
            armed = 1'b1;
            msg = MSG_ARMED;
            digit_count = 0;
          end else if (disarm_req) begin
            armed = 1'b0;
            msg = MSG_DISARMED;
            buzzer = 1'b0;
            digit_count = 0;
          end
          arm_req = 1'b0;
          disarm_req = 1'b0;
        end
        if (code == KEY_ARM) begin
          msg = MSG_ASK_ARM;
          arm_req = 1'b1;
        end else if (code == KEY_DISARM) begin
          msg = MSG_ASK_DISARM;
          disarm_req = 1'b1;
        end
        // digits only count while a request waits; overflow digits are counted, not kept
        if (arm_req || disarm_req) begin
          for (k = 0; k < NUM_DIGIT_KEYS; k++) begin
            if (code == DIGIT_KEYS[k]) begin
              msg = MSG_DIGIT;
              held_digit = k[3:0];
              if (digit_count < CODE_LEN) entered[digit_count[1:0]] = k[3:0];
              if (digit_count <= CODE_LEN) digit_count++;
            end
          end
        end
      end else begin
        // rising motion while armed raises alert and buzzer once per motion
        if (armed) begin
          if (motion) begin
            if (!motion_seen) begin
              alert = 1'b1;
              buzzer = 1'b1;
              msg = MSG_DETECTED;
              motion_seen = 1'b1;
            end
          end else begin
            motion_seen = 1'b0;
          end
        end
        // button press (falling level) toggles arming
        if (last_button && !button) begin
          if (!armed) begin
            armed = 1'b1;
            msg = MSG_ARMED;
          end else begin
            armed = 1'b0;
            msg = MSG_DISARMED;
            motion_seen = 1'b0;
          end
        end
        last_button = button;
      end
      res.armed       = armed;
      res.alert       = alert;
      res.buzzer      = buzzer;
      res.message     = msg;
      res.shown_digit = (msg == MSG_DIGIT) ? held_digit : 4'd0;
      expected_results.push_back(res);
    endfunction

    function void flag_field(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result transaction %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.armed !== want.armed) flag_field("armed", want.armed, got.armed);
      if (got.alert !== want.alert) flag_field("alert", want.alert, got.alert);
      if (got.buzzer !== want.buzzer) flag_field("buzzer", want.buzzer, got.buzzer);
      if (got.message !== want.message) flag_field("message", want.message, got.message);
      if (got.shown_digit !== want.shown_digit)
        flag_field("shown_digit", want.shown_digit, got.shown_digit);
      if (want.message == MSG_ARMED) n_armed++;
      if (want.message == MSG_DETECTED) n_detected++;
      if (want.message == MSG_RETRY) n_retry++;
    endfunction
  endclass

  panel_predictor panel;

  keycode_alarm_controller DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_ir_code      (in_ir_code),
    .in_motion_level (in_motion_level),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_armed       (out_armed),
    .out_alert       (out_alert),
    .out_buzzer      (out_buzzer),
    .out_message     (out_message),
    .out_shown_digit (out_shown_digit)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short idle gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // Result side back-pressure: alternating free and stalled runs
  initial begin
    int run;
    bit hold;
    out_stall = 1'b0;
    run = 0;
    hold = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        hold = ($urandom_range(0, 2) == 0);
        run = hold ? pick_gap() + 1 : $urandom_range(1, 30);
      end
      run--;
      out_stall <= hold && !burst_mode;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result.armed       = out_armed;
      seen_result.alert       = out_alert;
      seen_result.buzzer      = out_buzzer;
      seen_result.message     = msg_t'(out_message);
      seen_result.shown_digit = out_shown_digit;
      panel.check_result(seen_result);
    end
  end

  // Drive one input transaction; entered and left at a falling edge
  task automatic send_event(input bit kind, input bit [31:0] code, input bit motion,
                            input bit button);
    int        gap;
    bit [31:0] ir;
    bit        m, b;
    // fields that the event kind ignores still carry random values
    ir  = kind ? $urandom : code;
    m   = kind ? motion : bit'($urandom_range(0, 1));
    b   = kind ? button : bit'($urandom_range(0, 1));
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_ir_code      <= ir;
    in_motion_level <= m;
    in_button_level <= b;
    do @(posedge clk); while (in_stall);
    panel.note_event(kind, ir, m, b);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_sample();
    if ($urandom_range(0, 2) == 0) motion_now = ~motion_now;
    if ($urandom_range(0, 3) == 0) button_now = ~button_now;
    send_event(1'b1, 32'd0, motion_now, button_now);
  endtask

  // Key a digit sequence from the stored passcode, optionally with one digit wrong
  task automatic enter_digits(input int count, input bit corrupt, input bit mix);
    int i, d, bad_pos;
    bad_pos = corrupt ? $urandom_range(0, count - 1) : -1;
    for (i = 0; i < count; i++) begin
      d = (i < CODE_LEN) ? panel.passcode[i] : $urandom_range(0, 9);
      if (i == bad_pos) d = (d + $urandom_range(1, 9)) % 10;
      if (mix && $urandom_range(0, 9) == 0) send_sample();
      send_event(1'b0, DIGIT_KEYS[d], 1'b0, 1'b0);
    end
  endtask

  // Write the passcode once the panel has gone quiet
  task automatic load_passcode(input bit [3:0] digits [NUM_CODE_DIGITS]);
    int i;
    in_valid <= 1'b0;
    while (panel.expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    for (i = 0; i < NUM_CODE_DIGITS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_CODE_DIGIT0 + i[1:0];
      cfg_wdata <= digits[i];
      panel.set_passcode_digit(i, digits[i]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    passcodes_loaded++;
  endtask

  // Watchdog
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus
  initial begin
    bit [3:0]  code [NUM_CODE_DIGITS];
    bit [31:0] key;
    int        i, pick, r, len, phase_mark, phases;
    panel           = new();
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = REG_CODE_DIGIT0;
    cfg_wdata       = 4'd0;
    in_valid        = 1'b0;
    in_kind         = 1'b0;
    in_ir_code      = 32'd0;
    in_motion_level = 1'b0;
    in_button_level = 1'b0;
    burst_mode      = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    code = '{4'd9, 4'd0, 4'd9, 4'd0};
    load_passcode(code);

    // Directed: unknown codes, digit without request
    send_event(1'b0, 32'h0000_0000, 1'b0, 1'b0);
    send_event(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_event(1'b0, DIGIT_KEYS[5], 1'b0, 1'b0);
    // button arms, motion detected once, held motion ignored, button disarms
    send_event(1'b1, 32'd0, 1'b0, 1'b1);
    send_event(1'b1, 32'd0, 1'b0, 1'b0);
    send_event(1'b1, 32'd0, 1'b1, 1'b0);
    send_event(1'b1, 32'd0, 1'b1, 1'b1);
    send_event(1'b1, 32'd0, 1'b0, 1'b0);
    // both requests with a matching code: arming wins
    send_event(1'b0, KEY_ARM, 1'b0, 1'b0);
    send_event(1'b0, KEY_DISARM, 1'b0, 1'b0);
    enter_digits(CODE_LEN, 1'b0, 1'b0);
    send_event(1'b0, KEY_DISARM, 1'b0, 1'b0);
    // wrong code gives retry, then an over-long entry gives retry with request kept
    enter_digits(CODE_LEN, 1'b1, 1'b0);
    send_event(1'b0, KEY_DISARM, 1'b0, 1'b0);
    enter_digits(CODE_LEN + 1, 1'b0, 1'b0);
    send_event(1'b0, 32'h00FF_0000, 1'b0, 1'b0);

    // Random phases, passcode changed between them
    phase_mark = sent;
    phases = 0;
    while (sent < ITEM_TARGET) begin
      if (sent >= phase_mark + PHASE_ITEMS) begin
        phase_mark = sent;
        phases++;
        for (i = 0; i < NUM_CODE_DIGITS; i++)
          case (phases % 4)
            1: code[i] = 4'd0;
            2: code[i] = 4'd9;
            default: code[i] = $urandom_range(0, 9);
          endcase
        load_passcode(code);
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // request, entry, usually a key that settles it
        r = $urandom_range(0, 9);
        if (r < 5) begin
          send_event(1'b0, KEY_ARM, 1'b0, 1'b0);
        end else if (r < 8) begin
          send_event(1'b0, KEY_DISARM, 1'b0, 1'b0);
        end else begin
          key = $urandom_range(0, 1) ? KEY_ARM : KEY_DISARM;
          send_event(1'b0, key, 1'b0, 1'b0);
          send_event(1'b0, (key == KEY_ARM) ? KEY_DISARM : KEY_ARM, 1'b0, 1'b0);
        end
        r = $urandom_range(0, 9);
        if (r < 7) len = CODE_LEN;
        else if (r == 7) len = $urandom_range(0, CODE_LEN - 1);
        else len = CODE_LEN + $urandom_range(1, 3);
        enter_digits(len, $urandom_range(0, 4) == 0, 1'b1);
        if ($urandom_range(0, 3) != 0) send_event(1'b0, $urandom, 1'b0, 1'b0);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) send_sample();
      end else begin
        // noise: random codes, near misses of real keys, stray keys
        r = $urandom_range(0, 3);
        case (r)
          0: key = $urandom;
          1: key = DIGIT_KEYS[$urandom_range(0, 9)] ^ (32'd1 << $urandom_range(0, 31));
          2: key = DIGIT_KEYS[$urandom_range(0, 9)];
          default: key = $urandom_range(0, 1) ? KEY_ARM : KEY_DISARM;
        endcase
        send_event(1'b0, key, 1'b0, 1'b0);
      end
    end

    // Drain
    in_valid <= 1'b0;
    burst_mode = 1'b0;
    while (panel.expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Checked %0d results from %0d events under %0d passcodes;", panel.checked,
             sent, passcodes_loaded);
    $display("  %0d armed, %0d detected and %0d retry messages expected.", panel.n_armed,
             panel.n_detected, panel.n_retry);
    if (panel.mismatches == 0 && panel.expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[keycode_alarm_controller.f]
+incdir+hdl
hdl/kac_pkg.sv
hdl/kac_key_decode.sv
hdl/kac_core.sv
hdl/keycode_alarm_controller.sv
tb/sv/tb.sv
